// ===== design/bsrq_pkg.sv =====
// ----------------------------------------------------------------------------
// bsrq_pkg
// Shared constants and types for the buffer swap ring queue: ring size,
// handle and counter widths, request and error codes, slot store command.
// ----------------------------------------------------------------------------
package bsrq_pkg;

    // Ring geometry.
    localparam int CAPACITY = 32;
    localparam int HANDLE_W = 6;
    localparam int SLOT_AW  = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    // Request types.
    localparam logic [1:0] REQ_ENQUEUE  = 2'd0;
    localparam logic [1:0] REQ_DEQUEUE  = 2'd1;
    localparam logic [1:0] REQ_CLOSE    = 2'd2;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_OK            = 2'd0;
    localparam logic [1:0] ERR_ENQ_SPARE     = 2'd1;
    localparam logic [1:0] ERR_DEQ_SPARE     = 2'd2;
    localparam logic [1:0] ERR_UNKNOWN_CLOSE = 2'd3;

    // Access command from the control logic to the slot store.
    typedef struct packed {
        logic                rd_en;
        logic [SLOT_AW-1:0]  rd_addr;
        logic                wr_en;
        logic [SLOT_AW-1:0]  wr_addr;
        logic [HANDLE_W-1:0] wr_data;
    } slot_cmd_t;

endpackage

// ===== design/bsrq_ram.sv =====
// ----------------------------------------------------------------------------
// bsrq_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bsrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/bsrq_slot_store.sv =====
// ----------------------------------------------------------------------------
// bsrq_slot_store
// Ring slot storage: a RAM plus one written flag per slot, so that a slot
// that was never written since reset reads back its own index.
// ----------------------------------------------------------------------------
module bsrq_slot_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bsrq_pkg::slot_cmd_t           cmd,
    output logic [bsrq_pkg::HANDLE_W-1:0] rd_data
);
    import bsrq_pkg::*;

    logic [CAPACITY-1:0] written_reg;
    logic [SLOT_AW-1:0]  rd_addr_reg;
    logic [HANDLE_W-1:0] ram_q;

    bsrq_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (cmd.wr_addr),
        .wr_data (cmd.wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (ram_q)
    );

    // Written flags; reset returns every slot to its initial handle at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (cmd.wr_en)
        begin
            written_reg[cmd.wr_addr] <= 1'b1;
        end
    end

    // Track the address of the data now on the RAM output.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_addr_reg <= cmd.rd_addr;
        end
    end

    // An unwritten slot holds its own index.
    assign rd_data = written_reg[rd_addr_reg] ? ram_q : HANDLE_W'(rd_addr_reg);

endmodule

// ===== design/buffer_swap_ring_queue.sv =====
// ----------------------------------------------------------------------------
// buffer_swap_ring_queue
// Ring of buffer handles in which filled and free buffers are exchanged.
// ----------------------------------------------------------------------------
// Usage:
// A request (req_type, handle_present, handle_in) is taken on the input
// channel when in_valid is high and in_stall is low. Enqueue swaps the given
// handle into the ring at head plus count, dequeue swaps at the head, close
// hands a buffer back as the dequeue spare. Each request gives exactly one
// result on the output channel (handle_valid, handle_out, overflow,
// error_code, fill_level), taken when out_valid is high and out_stall low.
// The slot RAM is read at the edge that accepts a request and the slot is
// written back at the edge that completes it, which also loads the result
// and raises out_valid; the block takes no new request (in_stall high) until
// the last one completes. The output register lets the next request enter
// while a result waits; if the receiver stalls, the following request holds
// before its write-back until the output register is free.
// Reset empties the ring, restores both spares and the initial slot contents
// at once (per-slot written flags, no clearing pass), clears ignore_overflows;
// the user sets it via cfg_wr_en/cfg_wr_data only while idle (not enforced).
// ----------------------------------------------------------------------------
module buffer_swap_ring_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    // Request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    req_type,
    input  logic                          handle_present,
    input  logic [bsrq_pkg::HANDLE_W-1:0] handle_in,
    // Result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          handle_valid,
    output logic [bsrq_pkg::HANDLE_W-1:0] handle_out,
    output logic                          overflow,
    output logic [1:0]                    error_code,
    output logic [bsrq_pkg::COUNT_W-1:0]  fill_level
);
    import bsrq_pkg::*;

    // Control and ring state.
    logic                ignore_ovf_reg;
    logic [SLOT_AW-1:0]  head_reg,      head_next;
    logic [COUNT_W-1:0]  count_reg,     count_next;
    logic [HANDLE_W-1:0] enq_spare_reg, enq_spare_next;
    logic                enq_sv_reg,    enq_sv_next;
    logic [HANDLE_W-1:0] deq_spare_reg, deq_spare_next;
    logic                deq_sv_reg,    deq_sv_next;

    // Request held during execution.
    logic                exec_valid_reg;
    logic [1:0]          req_reg;
    logic                present_reg;
    logic [HANDLE_W-1:0] hin_reg;
    logic [SLOT_AW-1:0]  addr_reg;

    // Output register.
    logic                out_valid_reg;
    logic                hv_reg,   hv_next;
    logic [HANDLE_W-1:0] hout_reg, hout_next;
    logic                ovf_reg,  ovf_next;
    logic [1:0]          err_reg,  err_next;

    logic                accept;
    logic                done;
    logic [SLOT_AW:0]    pos_sum;
    logic [SLOT_AW-1:0]  tail_pos;
    logic [SLOT_AW-1:0]  head_inc;
    logic                slot_wr;
    logic [HANDLE_W-1:0] slot_wdata;
    logic [HANDLE_W-1:0] slot_q;
    slot_cmd_t           slot_cmd;

    assign in_stall = exec_valid_reg;
    assign accept   = in_valid && !exec_valid_reg;
    assign done     = exec_valid_reg && (!out_valid_reg || !out_stall);

    // Slot at head plus count, wrapped into the ring.
    assign pos_sum  = (SLOT_AW + 1)'(head_reg) + (SLOT_AW + 1)'(count_reg);
    assign tail_pos = (pos_sum >= (SLOT_AW + 1)'(CAPACITY))
                      ? SLOT_AW'(pos_sum - (SLOT_AW + 1)'(CAPACITY))
                      : SLOT_AW'(pos_sum);
    assign head_inc = (head_reg == SLOT_AW'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;

    // Slot store access: read at acceptance, write back on completion.
    always_comb
    begin
        slot_cmd.rd_en   = accept;
        slot_cmd.rd_addr = (req_type == REQ_ENQUEUE) ? tail_pos : head_reg;
        slot_cmd.wr_en   = done && slot_wr;
        slot_cmd.wr_addr = addr_reg;
        slot_cmd.wr_data = slot_wdata;
    end

    bsrq_slot_store u_slots (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (slot_cmd),
        .rd_data (slot_q)
    );

    // Request execution: swap the slot and update counters and spares.
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        enq_spare_next = enq_spare_reg;
        enq_sv_next    = enq_sv_reg;
        deq_spare_next = deq_spare_reg;
        deq_sv_next    = deq_sv_reg;
        hv_next        = 1'b0;
        hout_next      = '0;
        ovf_next       = 1'b0;
        err_next       = ERR_OK;
        slot_wr        = 1'b0;
        slot_wdata     = hin_reg;
        unique case (req_reg)
            REQ_ENQUEUE:
            begin
                if (!present_reg)
                begin
                    if (!enq_sv_reg)
                    begin
                        err_next = ERR_ENQ_SPARE;
                    end
                    else
                    begin
                        hv_next        = 1'b1;
                        hout_next      = enq_spare_reg;
                        enq_sv_next    = 1'b0;
                        enq_spare_next = '0;
                    end
                end
                else
                begin
                    hv_next   = 1'b1;
                    hout_next = slot_q;
                    slot_wr   = 1'b1;
                    if (count_reg < COUNT_W'(CAPACITY))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        head_next = head_inc;
                        ovf_next  = !ignore_ovf_reg;
                    end
                end
            end
            REQ_DEQUEUE:
            begin
                if (count_reg != '0)
                begin
                    if (!present_reg && !deq_sv_reg)
                    begin
                        err_next = ERR_DEQ_SPARE;
                    end
                    else
                    begin
                        if (!present_reg)
                        begin
                            slot_wdata     = deq_spare_reg;
                            deq_sv_next    = 1'b0;
                            deq_spare_next = '0;
                        end
                        hv_next    = 1'b1;
                        hout_next  = slot_q;
                        slot_wr    = 1'b1;
                        count_next = count_reg - 1'b1;
                        head_next  = head_inc;
                    end
                end
            end
            REQ_CLOSE:
            begin
                if (deq_sv_reg)
                begin
                    if (present_reg)
                    begin
                        err_next = ERR_UNKNOWN_CLOSE;
                    end
                end
                else if (present_reg)
                begin
                    deq_spare_next = hin_reg;
                    deq_sv_next    = 1'b1;
                end
            end
            default:
            begin
                // Unused request type: null result, no state change.
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ignore_ovf_reg <= 1'b0;
            head_reg       <= '0;
            count_reg      <= '0;
            enq_spare_reg  <= HANDLE_W'(CAPACITY);
            enq_sv_reg     <= 1'b1;
            deq_spare_reg  <= HANDLE_W'(CAPACITY + 1);
            deq_sv_reg     <= 1'b1;
            exec_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ignore_ovf_reg <= cfg_wr_data;
            end
            if (done)
            begin
                head_reg      <= head_next;
                count_reg     <= count_next;
                enq_spare_reg <= enq_spare_next;
                enq_sv_reg    <= enq_sv_next;
                deq_spare_reg <= deq_spare_next;
                deq_sv_reg    <= deq_sv_next;
            end
            exec_valid_reg <= accept || (exec_valid_reg && !done);
            out_valid_reg  <= done || (out_valid_reg && out_stall);
        end
    end

    // Request capture at acceptance.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg     <= req_type;
            present_reg <= handle_present;
            hin_reg     <= handle_in;
            addr_reg    <= slot_cmd.rd_addr;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            hv_reg   <= hv_next;
            hout_reg <= hout_next;
            ovf_reg  <= ovf_next;
            err_reg  <= err_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign handle_valid = hv_reg;
    assign handle_out   = hout_reg;
    assign overflow     = ovf_reg;
    assign error_code   = err_reg;
    assign fill_level   = count_reg;

`ifndef NO_ASSERTIONS
    // An accepted request is executing in the next cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> exec_valid_reg)
        else $error("accepted request did not reach execution");

    // The fill level never exceeds the ring size.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fill_level <= COUNT_W'(CAPACITY)))
        else $error("fill level above capacity");

    // Overflow only comes with a returned handle and no error.
    a_ovf_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |-> (handle_valid && error_code == ERR_OK))
        else $error("overflow on a failed request");

    // A null result carries a zero handle.
    a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !handle_valid) |-> (handle_out == '0))
        else $error("null result with nonzero handle");
`endif

endmodule
